@@ design/sirs_lattice_site_update_assert.svh @@
// ============================================================================
// SIRS lattice site update - assertion macros
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef SIRS_LATTICE_SITE_UPDATE_ASSERT_SVH
`define SIRS_LATTICE_SITE_UPDATE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SLSU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slsu assertion failed");
`define SLSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slsu assertion failed");
`else
`define SLSU_ASSERT_SAME(lbl, ante, cons)
`define SLSU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/slsu_pkg.sv @@
// ============================================================================
// SIRS lattice site update - package
// Shared types and constants.
// ============================================================================
`default_nettype none

package slsu_pkg;

    localparam int          QW      = 17;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;
    localparam int          PAW     = 4;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [PAW-1:0] ADDR_P_INFECT = 4'h0;
    localparam logic [PAW-1:0] ADDR_P_RECOVER = 4'h4;
    localparam logic [PAW-1:0] ADDR_P_RESUS  = 4'h8;

    typedef enum logic [1:0] {
        ST_SUS = 2'd0,
        ST_INF = 2'd1,
        ST_REC = 2'd2,
        ST_VAC = 2'd3
    } site_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_UPDATE,
        OP_READ,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_OLD,
        B_NBR,
        B_FIN
    } bstate_t;

    typedef struct packed {
        logic             busy;
        logic [3:0][16:0] thr;
        logic [16:0]      p_recover;
        logic [16:0]      p_resus;
    } cfg_t;

    // nbr_ok order: up, down, left, right
    typedef struct packed {
        op_t         op;
        logic [3:0]  nbr_ok;
        logic [1:0]  status_in;
        logic [15:0] rand_value;
    } item_t;

endpackage

`default_nettype wire

@@ design/slsu_cfg.sv @@
// ============================================================================
// SIRS lattice site update - configuration
// APB registers and the sequential infection threshold builder.
// ============================================================================
`default_nettype none

module slsu_cfg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [slsu_pkg::PAW-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output slsu_pkg::cfg_t                cfg
);

    logic [16:0]      p_infect_reg;
    logic [16:0]      p_recover_reg;
    logic [16:0]      p_resus_reg;
    logic [3:0][16:0] thr_reg;
    logic [16:0]      s_reg;
    logic [16:0]      q_reg;
    logic [1:0]       k_reg;
    logic             busy_reg;
    logic             wr;
    logic [16:0]      wv;
    logic [16:0]      sat;
    logic [33:0]      prod;
    logic [33:0]      sum;
    logic [16:0]      s_next;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign wv     = pwdata[16:0];
    assign sat    = (wv > slsu_pkg::ONE_Q16) ? slsu_pkg::ONE_Q16 : wv;
    assign prod   = s_reg * q_reg;
    assign sum    = prod + {17'd0, slsu_pkg::HALF_Q16};
    assign s_next = sum[32:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_infect_reg  <= '0;
            p_recover_reg <= '0;
            p_resus_reg   <= '0;
            thr_reg       <= '0;
            s_reg         <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (wr && paddr == slsu_pkg::ADDR_P_INFECT)
            begin
                p_infect_reg <= sat;
                q_reg        <= slsu_pkg::ONE_Q16 - sat;
                s_reg        <= slsu_pkg::ONE_Q16;
                k_reg        <= '0;
                busy_reg     <= 1'b1;
            end
            else if (busy_reg)
            begin
                s_reg          <= s_next;
                thr_reg[k_reg] <= slsu_pkg::ONE_Q16 - s_next;
                k_reg          <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (wr && paddr == slsu_pkg::ADDR_P_RECOVER)
            begin
                p_recover_reg <= sat;
            end
            if (wr && paddr == slsu_pkg::ADDR_P_RESUS)
            begin
                p_resus_reg <= sat;
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            slsu_pkg::ADDR_P_INFECT:  prdata = {15'd0, p_infect_reg};
            slsu_pkg::ADDR_P_RECOVER: prdata = {15'd0, p_recover_reg};
            slsu_pkg::ADDR_P_RESUS:   prdata = {15'd0, p_resus_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.busy      = busy_reg;
    assign cfg.thr       = thr_reg;
    assign cfg.p_recover = p_recover_reg;
    assign cfg.p_resus   = p_resus_reg;

endmodule

`default_nettype wire

@@ design/slsu_front.sv @@
// ============================================================================
// SIRS lattice site update - front end
// Accepts items, classifies them and queues them for the back end.
// ============================================================================
`default_nettype none

module slsu_front #(
    parameter int GRID_SIDE = 256,
    parameter int AW        = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     command,
    input  wire logic [7:0]     row,
    input  wire logic [7:0]     col,
    input  wire logic [1:0]     status_in,
    input  wire logic [15:0]    rand_value,
    input  wire logic           busy,
    output logic                head_valid,
    output slsu_pkg::item_t     head_item,
    output logic [AW-1:0]       head_addr,
    input  wire logic           pop
);

    slsu_pkg::item_t item_q [2];
    logic [AW-1:0]   addr_q [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            in_range;
    slsu_pkg::item_t cls;
    logic [AW-1:0]   addr;

    assign in_range = (32'(row) < GRID_SIDE) && (32'(col) < GRID_SIDE);
    assign addr     = AW'(32'(row) * GRID_SIDE + 32'(col));

    always_comb
    begin
        cls.status_in  = status_in;
        cls.rand_value = rand_value;
        cls.nbr_ok[3]  = (row != 8'd0);
        cls.nbr_ok[2]  = (32'(row) + 32'd1 < GRID_SIDE);
        cls.nbr_ok[1]  = (col != 8'd0);
        cls.nbr_ok[0]  = (32'(col) + 32'd1 < GRID_SIDE);
        cls.op         = slsu_pkg::OP_NONE;
        if (in_range)
        begin
            unique case (command)
                slsu_pkg::CMD_WRITE:  cls.op = slsu_pkg::OP_WRITE;
                slsu_pkg::CMD_UPDATE: cls.op = slsu_pkg::OP_UPDATE;
                slsu_pkg::CMD_READ:   cls.op = slsu_pkg::OP_READ;
                default:              cls.op = slsu_pkg::OP_NONE;
            endcase
        end
    end

    assign in_stall   = (count_reg == 2'd2) || busy;
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = item_q[rd_ptr_reg];
    assign head_addr  = addr_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_q[wr_ptr_reg] <= cls;
            addr_q[wr_ptr_reg] <= addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/slsu_back.sv @@
// ============================================================================
// SIRS lattice site update - back end
// Site store, neighbour scan sequencer and result register.
// ============================================================================
`default_nettype none

module slsu_back #(
    parameter int GRID_SIDE = 256,
    parameter int AW        = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire slsu_pkg::cfg_t  cfg,
    input  wire logic            head_valid,
    input  wire slsu_pkg::item_t head_item,
    input  wire logic [AW-1:0]   head_addr,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [1:0]           status_out,
    output logic                 changed
);

    localparam int DEPTH = 1 << AW;

    logic [1:0]        mem [DEPTH];
    logic [1:0]        rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              we;

    slsu_pkg::bstate_t state_reg, state_next;
    slsu_pkg::item_t   item_reg;
    logic [AW-1:0]     addr_reg;
    logic [1:0]        old_reg;
    logic [1:0]        idx_reg, idx_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              out_valid_reg;
    logic [1:0]        status_out_reg;
    logic              changed_reg;
    logic              slot_free;
    logic              fin;
    logic [1:0]        now;
    logic [1:0]        old_eff;
    logic [16:0]       thr;

    function automatic logic [AW-1:0] nbr_addr(input logic [AW-1:0] a, input logic [1:0] i);
        logic [AW-1:0] r;
        begin
            r = a;
            unique case (i)
                2'd0:    r = a - AW'(GRID_SIDE);
                2'd1:    r = a + AW'(GRID_SIDE);
                2'd2:    r = a - AW'(1);
                default: r = a + AW'(1);
            endcase
            return r;
        end
    endfunction

    assign slot_free = !out_valid_reg || !out_stall;
    assign thr       = cfg.thr[2'(cnt_reg - 3'd1)];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        fin        = 1'b0;
        rd_addr    = addr_reg;
        unique case (state_reg)
            slsu_pkg::B_IDLE:
            begin
                rd_addr = head_addr;
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_item.op == slsu_pkg::OP_NONE)
                    begin
                        state_next = slsu_pkg::B_FIN;
                    end
                    else
                    begin
                        state_next = slsu_pkg::B_OLD;
                    end
                end
            end
            slsu_pkg::B_OLD:
            begin
                rd_addr  = nbr_addr(addr_reg, 2'd0);
                idx_next = '0;
                cnt_next = '0;
                if (item_reg.op == slsu_pkg::OP_UPDATE && rd_data_reg == slsu_pkg::ST_SUS)
                begin
                    state_next = slsu_pkg::B_NBR;
                end
                else
                begin
                    state_next = slsu_pkg::B_FIN;
                end
            end
            slsu_pkg::B_NBR:
            begin
                rd_addr = nbr_addr(addr_reg, idx_reg + 2'd1);
                if (item_reg.nbr_ok[~idx_reg] && rd_data_reg == slsu_pkg::ST_INF)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = slsu_pkg::B_FIN;
                end
            end
            slsu_pkg::B_FIN:
            begin
                if (slot_free)
                begin
                    fin        = 1'b1;
                    state_next = slsu_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = slsu_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        old_eff = old_reg;
        now     = old_reg;
        unique case (item_reg.op)
            slsu_pkg::OP_WRITE:  now = item_reg.status_in;
            slsu_pkg::OP_READ:   now = old_reg;
            slsu_pkg::OP_UPDATE:
            begin
                unique case (old_reg)
                    slsu_pkg::ST_SUS:
                        if (cnt_reg != 3'd0 && {1'b0, item_reg.rand_value} < thr)
                        begin
                            now = slsu_pkg::ST_INF;
                        end
                    slsu_pkg::ST_INF:
                        if ({1'b0, item_reg.rand_value} < cfg.p_recover)
                        begin
                            now = slsu_pkg::ST_REC;
                        end
                    slsu_pkg::ST_REC:
                        if ({1'b0, item_reg.rand_value} < cfg.p_resus)
                        begin
                            now = slsu_pkg::ST_SUS;
                        end
                    default: now = old_reg;
                endcase
            end
            default:
            begin
                old_eff = slsu_pkg::ST_SUS;
                now     = slsu_pkg::ST_SUS;
            end
        endcase
    end

    assign we = fin && (item_reg.op == slsu_pkg::OP_WRITE || item_reg.op == slsu_pkg::OP_UPDATE);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_reg] <= now;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
            addr_reg <= head_addr;
        end
        if (state_reg == slsu_pkg::B_OLD)
        begin
            old_reg <= rd_data_reg;
        end
        if (fin)
        begin
            status_out_reg <= now;
            changed_reg    <= (now != old_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slsu_pkg::B_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status_out = status_out_reg;
    assign changed    = changed_reg;

endmodule

`default_nettype wire

@@ design/sirs_lattice_site_update.sv @@
// The back end sequencer takes one item at a time: an unknown command goes
// straight to the result, read, write and non-updating items read the site, and
// an update of a susceptible site reads the site plus four neighbours through
// the single store read port, then writes back. The two-entry front end queue
// accepts items while the back end works. Writing p_infect holds input while thresholds are rebuilt.
// Reset clears configuration, control registers and thresholds; the site store is not cleared.
`default_nettype none

`include "sirs_lattice_site_update_assert.svh"

module sirs_lattice_site_update #(
    parameter int GRID_SIDE = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [slsu_pkg::PAW-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               command,
    input  wire logic [7:0]               row,
    input  wire logic [7:0]               col,
    input  wire logic [1:0]               status_in,
    input  wire logic [15:0]              rand_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status_out,
    output logic                          changed
);

    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);

    slsu_pkg::cfg_t  cfg;
    slsu_pkg::item_t head_item;
    logic [AW-1:0]   head_addr;
    logic            head_valid;
    logic            pop;
    logic            infect_wr;

    assign infect_wr = psel && penable && pwrite && paddr == slsu_pkg::ADDR_P_INFECT;

    slsu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slsu_front #(
        .GRID_SIDE (GRID_SIDE),
        .AW        (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .row        (row),
        .col        (col),
        .status_in  (status_in),
        .rand_value (rand_value),
        .busy       (cfg.busy),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_addr  (head_addr),
        .pop        (pop)
    );

    slsu_back #(
        .GRID_SIDE (GRID_SIDE),
        .AW        (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_addr  (head_addr),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status_out (status_out),
        .changed    (changed)
    );

    `SLSU_ASSERT_SAME(a_busy_stalls, cfg.busy, in_stall)
    `SLSU_ASSERT_NEXT(a_infect_wr_busy, infect_wr, cfg.busy)
    `SLSU_ASSERT_SAME(a_pop_has_data, pop, head_valid)

endmodule

`default_nettype wire

@@ bench/sirs_lattice_site_update_test.sv @@
// ============================================================================
// SIRS lattice site update - testbench
// Drives write, read and update transfers with random idling on both sides,
// predicts each site result from its own lattice copy and checks it in order.
// ============================================================================
`timescale 1ns / 100ps

module sirs_lattice_site_update_test;

    localparam logic [1:0]               CMD_NOP     = 2'd3;
    localparam logic [slsu_pkg::PAW-1:0] ADDR_UNUSED = 4'hC;
    localparam int                       SIDE        = 256;

    typedef struct {
        slsu_pkg::site_t status;
        logic            changed;
    } site_result_t;

    class lattice_board;
        slsu_pkg::site_t cells [SIDE*SIDE];
        bit              written [SIDE*SIDE];
        logic [16:0]     thr [4];
        logic [16:0]     p_rec;
        logic [16:0]     p_res;
        site_result_t    due [$];
        int              errors;

        function new();
            p_rec = '0;
            p_res = '0;
            errors = 0;
            set_reg(slsu_pkg::ADDR_P_INFECT, 32'd0);
        endfunction

        function void set_reg(logic [slsu_pkg::PAW-1:0] addr, logic [31:0] data);
            logic [16:0] v;
            logic [63:0] q, s;
            v = data[16:0];
            if (v > slsu_pkg::ONE_Q16)
                v = slsu_pkg::ONE_Q16;
            if (addr == slsu_pkg::ADDR_P_INFECT) begin
                q = 64'(slsu_pkg::ONE_Q16 - v);
                s = 64'(slsu_pkg::ONE_Q16);
                for (int k = 0; k < 4; k++) begin
                    s = (s * q + 64'd32768) >> 16;
                    thr[k] = slsu_pkg::ONE_Q16 - s[16:0];
                end
            end else if (addr == slsu_pkg::ADDR_P_RECOVER)
                p_rec = v;
            else if (addr == slsu_pkg::ADDR_P_RESUS)
                p_res = v;
        endfunction

        function logic is_inf(int r, int c);
            if (r < 0 || c < 0 || r >= SIDE || c >= SIDE)
                return 1'b0;
            return cells[r*SIDE+c] == slsu_pkg::ST_INF;
        endfunction

        function void note(logic [1:0] cmd, logic [7:0] r, logic [7:0] c,
                           logic [1:0] st, logic [15:0] rnd);
            site_result_t res;
            slsu_pkg::site_t old, now;
            int n, a;
            res.status = slsu_pkg::ST_SUS;
            res.changed = 0;
            if (cmd != CMD_NOP) begin
                a = r * SIDE + c;
                old = cells[a];
                now = old;
                if (cmd == slsu_pkg::CMD_WRITE) begin
                    now = slsu_pkg::site_t'(st);
                    written[a] = 1;
                end else if (cmd == slsu_pkg::CMD_UPDATE) begin
                    if (old == slsu_pkg::ST_SUS) begin
                        n = is_inf(r-1, c) + is_inf(r+1, c) + is_inf(r, c-1) + is_inf(r, c+1);
                        if (n != 0 && {1'b0, rnd} < thr[n-1])
                            now = slsu_pkg::ST_INF;
                    end else if (old == slsu_pkg::ST_INF) begin
                        if ({1'b0, rnd} < p_rec)
                            now = slsu_pkg::ST_REC;
                    end else if (old == slsu_pkg::ST_REC) begin
                        if ({1'b0, rnd} < p_res)
                            now = slsu_pkg::ST_SUS;
                    end
                end
                cells[a] = now;
                res.status = now;
                res.changed = (now != old);
            end
            due.push_back(res);
        endfunction

        function void check(logic [1:0] st, logic ch);
            site_result_t e;
            if (due.size() == 0) begin
                $error("unexpected transfer: status_out %0d changed %0d", st, ch);
                errors++;
                return;
            end
            e = due.pop_front();
            if (st !== e.status) begin
                $error("status_out expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (ch !== e.changed) begin
                $error("changed expected %0d actual %0d", e.changed, ch);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [slsu_pkg::PAW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [7:0]  row = '0, col = '0;
    logic [1:0]  status_in = '0;
    logic [15:0] rand_value = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  status_out;
    logic        changed;

    int          idle_in = 0, idle_out = 0;
    logic        holding = 0;
    lattice_board board = new();

    sirs_lattice_site_update dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < idle_out);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check(status_out, changed);

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    task automatic reg_write(logic [slsu_pkg::PAW-1:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(addr, data);
        @(posedge clk);
    endtask

    task automatic send(logic [1:0] cmd, logic [7:0] r, logic [7:0] c,
                        logic [1:0] st, logic [15:0] rnd);
        while ($urandom_range(99) < idle_in) begin
            in_valid <= 0;
            @(posedge clk);
        end
        command <= cmd; row <= r; col <= c; status_in <= st; rand_value <= rnd;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        board.note(cmd, r, c, st, rnd);
    endtask

    task automatic settle();
        in_valid <= 0;
        while (board.due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // make sure a site and its neighbours hold known values before it is read
    task automatic prepare(logic [7:0] r, logic [7:0] c);
        int rr, cc;
        for (int k = 0; k < 5; k++) begin
            rr = r + (k == 1) - (k == 2);
            cc = c + (k == 3) - (k == 4);
            if (rr >= 0 && cc >= 0 && rr < SIDE && cc < SIDE && !board.written[rr*SIDE+cc])
                send(slsu_pkg::CMD_WRITE, 8'(rr), 8'(cc), 2'($urandom_range(3)),
                     16'($urandom));
        end
    endtask

    function automatic logic [7:0] pick();
        unique case ($urandom_range(2))
            0: return 8'($urandom_range(3));
            1: return 8'($urandom_range(255, 252));
            default: return 8'($urandom_range(128, 127));
        endcase
    endfunction

    task automatic random_items(int count);
        logic [7:0] r, c;
        logic [1:0] cmd;
        logic [15:0] rnd;
        int sel;
        for (int i = 0; i < count; i++) begin
            r = pick();
            c = pick();
            sel = $urandom_range(99);
            cmd = sel < 50 ? slsu_pkg::CMD_UPDATE : sel < 75 ? slsu_pkg::CMD_WRITE :
                  sel < 95 ? slsu_pkg::CMD_READ : CMD_NOP;
            rnd = $urandom_range(9) == 0 ? {16{$urandom_range(1) == 1}} : 16'($urandom);
            if (cmd == slsu_pkg::CMD_UPDATE || cmd == slsu_pkg::CMD_READ)
                prepare(r, c);
            send(cmd, r, c, 2'($urandom_range(3)), rnd);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        repeat (3) @(posedge clk);

        reg_write(slsu_pkg::ADDR_P_INFECT, 32'h8000);
        reg_write(slsu_pkg::ADDR_P_RECOVER, 32'h10000);
        reg_write(slsu_pkg::ADDR_P_RESUS, 32'hFFFF_FFFF);
        reg_write(ADDR_UNUSED, 32'h1234);

        send(slsu_pkg::CMD_WRITE, 8'd0, 8'd0, slsu_pkg::ST_SUS, 16'd0);
        send(slsu_pkg::CMD_WRITE, 8'd0, 8'd1, slsu_pkg::ST_INF, 16'd0);
        send(slsu_pkg::CMD_WRITE, 8'd1, 8'd0, slsu_pkg::ST_INF, 16'd0);
        send(slsu_pkg::CMD_WRITE, 8'd1, 8'd0, slsu_pkg::ST_INF, 16'd0);
        send(slsu_pkg::CMD_READ, 8'd0, 8'd1, 2'd0, 16'hFFFF);
        send(slsu_pkg::CMD_UPDATE, 8'd0, 8'd0, 2'd0, 16'hFFFF);
        send(slsu_pkg::CMD_UPDATE, 8'd0, 8'd0, 2'd0, 16'h0000);
        send(slsu_pkg::CMD_UPDATE, 8'd0, 8'd1, 2'd0, 16'hFFFF);
        send(slsu_pkg::CMD_UPDATE, 8'd0, 8'd1, 2'd0, 16'h0000);
        send(slsu_pkg::CMD_WRITE, 8'd255, 8'd255, slsu_pkg::ST_VAC, 16'd0);
        send(slsu_pkg::CMD_UPDATE, 8'd255, 8'd255, 2'd0, 16'd0);
        send(slsu_pkg::CMD_WRITE, 8'd255, 8'd254, slsu_pkg::ST_SUS, 16'd0);
        send(slsu_pkg::CMD_UPDATE, 8'd255, 8'd254, 2'd0, 16'd0);
        for (int k = 0; k < 5; k++)
            send(slsu_pkg::CMD_WRITE, 8'(5 + (k == 1) - (k == 2)), 8'(5 + (k == 3) - (k == 4)),
                 k == 0 ? slsu_pkg::ST_SUS : slsu_pkg::ST_INF, 16'd0);
        send(slsu_pkg::CMD_UPDATE, 8'd5, 8'd5, 2'd0, 16'hF000);
        send(CMD_NOP, 8'd255, 8'd255, slsu_pkg::ST_VAC, 16'hFFFF);
        send(slsu_pkg::CMD_READ, 8'd5, 8'd5, 2'd0, 16'd0);
        settle();

        reg_write(slsu_pkg::ADDR_P_INFECT, 32'h4000);
        reg_write(slsu_pkg::ADDR_P_RECOVER, 32'h8000);
        reg_write(slsu_pkg::ADDR_P_RESUS, 32'h3000);
        idle_in = 16; idle_out = 46;
        random_items(90);
        settle();

        reg_write(slsu_pkg::ADDR_P_INFECT, 32'h10000);
        reg_write(slsu_pkg::ADDR_P_RECOVER, 32'h0);
        reg_write(slsu_pkg::ADDR_P_RESUS, 32'hFFFF);
        idle_in = 46; idle_out = 16;
        random_items(90);
        settle();

        reg_write(slsu_pkg::ADDR_P_INFECT, 32'h0);
        reg_write(slsu_pkg::ADDR_P_RECOVER, 32'h1FFFF);
        reg_write(slsu_pkg::ADDR_P_RESUS, 32'h0);
        idle_in = 0; idle_out = 0;
        fork
            random_items(100);
            begin
                repeat (20) @(posedge clk);
                holding = 1;
                repeat (300) @(posedge clk);
                holding = 0;
            end
        join
        settle();

        if (board.errors == 0 && board.due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/slsu_pkg.sv
design/slsu_cfg.sv
design/slsu_front.sv
design/slsu_back.sv
design/sirs_lattice_site_update.sv
bench/sirs_lattice_site_update_test.sv
